[hw/rtl/slcd_pkg.sv]
package slcd_pkg;

  localparam int PAYLOAD_BYTES = 12;
  localparam int IDX_W         = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int ADDR_W        = IDX_W + 1;        // bank bit on top of byte index
  localparam int RAM_DEPTH     = 2 ** ADDR_W;
  localparam int CMDQ_DEPTH    = 2;
  localparam int CFG_IDX_W     = 1;

  localparam logic [7:0]       FIRST_SYNC_RST  = 8'd67;
  localparam logic [7:0]       SECOND_SYNC_RST = 8'd79;
  localparam logic [7:0]       LEN_BYTE        = 8'(PAYLOAD_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX        = IDX_W'(PAYLOAD_BYTES - 1);

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_SYNC  = 1'b0,
    CFG_SECOND_SYNC = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_LEN,
    PH_DATA,
    PH_SUM
  } phase_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_SEND
  } back_state_t;

  // one entry per finished frame, front to back
  typedef struct packed {
    logic err;
    logic bank;
  } cmd_t;

  // back tells front that a payload bank has been fully drained
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

endpackage

[hw/rtl/slcd_ifs.sv]
interface slcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [5:0] byte_index;
  logic       frame_status;
  logic       last;

  modport source (output valid, output data_byte, output byte_index,
                  output frame_status, output last, input ready);
  modport sink   (input valid, input data_byte, input byte_index,
                  input frame_status, input last, output ready);
endinterface

interface slcd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [slcd_pkg::CFG_IDX_W-1:0] index;
  logic [7:0]                     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/slcd_ram.sv]
module slcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/slcd_cmd_fifo.sv]
module slcd_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  slcd_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output slcd_pkg::cmd_t rd_data,
  output logic           empty
);

  localparam int PTR_W = (slcd_pkg::CMDQ_DEPTH > 1) ? $clog2(slcd_pkg::CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(slcd_pkg::CMDQ_DEPTH + 1);

  slcd_pkg::cmd_t   mem_r [slcd_pkg::CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign full    = (cnt_r == CNT_W'(slcd_pkg::CMDQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign push    = wr_en && !full;
  assign pop     = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(slcd_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(slcd_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[hw/rtl/slcd_front.sv]
module slcd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  slcd_in_if.sink                       in_if,
  input  logic [7:0]                    first_sync,
  input  logic [7:0]                    second_sync,
  output logic                          q_wr_en,
  output slcd_pkg::cmd_t                q_wr_data,
  input  logic                          q_full,
  input  slcd_pkg::release_t            rel,
  output logic                          ram_we,
  output logic [slcd_pkg::ADDR_W-1:0]   ram_waddr,
  output logic [7:0]                    ram_wdata
);

  slcd_pkg::phase_t            phase_r, phase_nxt;
  logic [7:0]                  sum_r, sum_nxt;
  logic [slcd_pkg::IDX_W-1:0]  cnt_r, cnt_nxt;
  logic                        bank_r, bank_nxt;
  logic [1:0]                  busy_r, busy_nxt;
  logic                        accept;
  logic                        sum_ok;

  assign accept = in_if.valid && in_if.ready;
  assign sum_ok = (sum_r == in_if.rx_byte);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      unique case (phase_r)
        slcd_pkg::PH_SYNC1: begin
          if (in_if.rx_byte == first_sync) phase_nxt = slcd_pkg::PH_SYNC2;
        end
        slcd_pkg::PH_SYNC2: begin
          phase_nxt = (in_if.rx_byte == second_sync) ? slcd_pkg::PH_LEN : slcd_pkg::PH_SYNC1;
        end
        slcd_pkg::PH_LEN: begin
          phase_nxt = (in_if.rx_byte == slcd_pkg::LEN_BYTE) ? slcd_pkg::PH_DATA
                                                            : slcd_pkg::PH_SYNC1;
        end
        slcd_pkg::PH_DATA: begin
          if (cnt_r == slcd_pkg::LAST_IDX) phase_nxt = slcd_pkg::PH_SUM;
        end
        default: phase_nxt = slcd_pkg::PH_SYNC1;
      endcase
    end
  end

  // handshake, store write and queue push
  always_comb begin
    unique case (phase_r)
      slcd_pkg::PH_DATA: in_if.ready = !busy_r[bank_r];
      slcd_pkg::PH_SUM:  in_if.ready = !q_full;
      default:           in_if.ready = 1'b1;
    endcase
    ram_we        = accept && (phase_r == slcd_pkg::PH_DATA);
    ram_waddr     = {bank_r, cnt_r};
    ram_wdata     = in_if.rx_byte;
    q_wr_en       = accept && (phase_r == slcd_pkg::PH_SUM);
    q_wr_data.err  = !sum_ok;
    q_wr_data.bank = bank_r;
  end

  // datapath and bank bookkeeping
  always_comb begin
    sum_nxt  = sum_r;
    cnt_nxt  = cnt_r;
    bank_nxt = bank_r;
    busy_nxt = busy_r;
    if (accept && (phase_r == slcd_pkg::PH_LEN) && (in_if.rx_byte == slcd_pkg::LEN_BYTE)) begin
      sum_nxt = '0;
      cnt_nxt = '0;
    end
    if (ram_we) begin
      sum_nxt = sum_r + in_if.rx_byte;
      cnt_nxt = cnt_r + 1'b1;
    end
    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    // a good frame locks its bank until the back end has sent it
    if (q_wr_en && sum_ok) begin
      busy_nxt[bank_r] = 1'b1;
      bank_nxt         = !bank_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= slcd_pkg::PH_SYNC1;
      sum_r   <= '0;
      cnt_r   <= '0;
      bank_r  <= 1'b0;
      busy_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
      bank_r  <= bank_nxt;
      busy_r  <= busy_nxt;
    end
  end

endmodule

[hw/rtl/slcd_back.sv]
module slcd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  slcd_pkg::cmd_t                q_rd_data,
  output logic                          q_rd_en,
  output logic                          ram_re,
  output logic [slcd_pkg::ADDR_W-1:0]   ram_raddr,
  input  logic [7:0]                    ram_rdata,
  output slcd_pkg::release_t            rel,
  slcd_out_if.source                    out_if
);

  slcd_pkg::back_state_t       state_r, state_nxt;
  slcd_pkg::cmd_t              cmd_r;
  logic [slcd_pkg::IDX_W-1:0]  idx_r;
  logic [7:0]                  data_r;
  logic [5:0]                  index_r;
  logic                        status_r;
  logic                        last_r;
  logic                        out_hs;

  assign out_hs = out_if.valid && out_if.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      slcd_pkg::B_IDLE: begin
        if (!q_empty) state_nxt = q_rd_data.err ? slcd_pkg::B_SEND : slcd_pkg::B_READ;
      end
      slcd_pkg::B_READ: state_nxt = slcd_pkg::B_SEND;
      slcd_pkg::B_SEND: begin
        if (out_hs) state_nxt = last_r ? slcd_pkg::B_IDLE : slcd_pkg::B_READ;
      end
      default: state_nxt = slcd_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_rd_en   = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = {cmd_r.bank, idx_r + 1'b1};
    unique case (state_r)
      slcd_pkg::B_IDLE: begin
        q_rd_en   = !q_empty;
        ram_re    = !q_empty && !q_rd_data.err;
        ram_raddr = {q_rd_data.bank, {slcd_pkg::IDX_W{1'b0}}};
      end
      slcd_pkg::B_SEND: ram_re = out_hs && !last_r;
      default: ;
    endcase
    out_if.valid        = (state_r == slcd_pkg::B_SEND);
    out_if.data_byte    = data_r;
    out_if.byte_index   = index_r;
    out_if.frame_status = status_r;
    out_if.last         = last_r;
    rel.valid = (state_r == slcd_pkg::B_SEND) && out_hs && last_r
                && (status_r == slcd_pkg::ST_OK);
    rel.bank  = cmd_r.bank;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slcd_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      slcd_pkg::B_IDLE: begin
        if (!q_empty) begin
          cmd_r    <= q_rd_data;
          idx_r    <= '0;
          data_r   <= '0;
          index_r  <= '0;
          status_r <= slcd_pkg::ST_ERR;
          last_r   <= 1'b1;
        end
      end
      slcd_pkg::B_READ: begin
        data_r   <= ram_rdata;
        index_r  <= 6'(idx_r);
        status_r <= slcd_pkg::ST_OK;
        last_r   <= (idx_r == slcd_pkg::LAST_IDX);
      end
      slcd_pkg::B_SEND: begin
        if (out_hs && !last_r) idx_r <= idx_r + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

[hw/rtl/sync_length_checksum_deframer.sv]
// Channel | Dir | Beat payload                                        | Handshake
// in_if   | in  | rx_byte[7:0]                                        | valid/ready
// out_if  | out | data_byte[7:0] byte_index[5:0] frame_status last    | valid/ready
// cfg_if  | in  | index[0] (0 first_sync, 1 second_sync), data[7:0]   | valid/ready, ready tied high
//
// Input bytes are taken one per cycle. Payload goes into a two-bank store, so a
// new frame is received while the previous one drains. Input stalls during the
// payload only while both banks hold frames not yet sent, and on the checksum
// byte while the two-entry frame queue is full.
// Output: each payload beat takes a registered store read, then the output
// register; the next beat's read starts only when out_if takes the current one;
// an error beat is offered in the cycle after its queue entry is picked up.
// rst_n is synchronous; the store contents are not cleared and need no pass.
module sync_length_checksum_deframer (
  input  logic        clk,
  input  logic        rst_n,
  slcd_in_if.sink     in_if,
  slcd_out_if.source  out_if,
  slcd_cfg_if.sink    cfg_if
);

  logic [7:0]                        first_sync_r;
  logic [7:0]                        second_sync_r;
  logic                              q_wr_en, q_rd_en, q_full, q_empty;
  slcd_pkg::cmd_t                    q_wr_data, q_rd_data;
  slcd_pkg::release_t                rel;
  logic                              ram_we, ram_re;
  logic [slcd_pkg::ADDR_W-1:0]       ram_waddr, ram_raddr;
  logic [7:0]                        ram_wdata, ram_rdata;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_sync_r  <= slcd_pkg::FIRST_SYNC_RST;
      second_sync_r <= slcd_pkg::SECOND_SYNC_RST;
    end else if (cfg_if.valid && cfg_if.ready) begin
      unique case (cfg_if.index)
        slcd_pkg::CFG_FIRST_SYNC:  first_sync_r  <= cfg_if.data;
        slcd_pkg::CFG_SECOND_SYNC: second_sync_r <= cfg_if.data;
        default: ;
      endcase
    end
  end

  slcd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_if),
    .first_sync  (first_sync_r),
    .second_sync (second_sync_r),
    .q_wr_en     (q_wr_en),
    .q_wr_data   (q_wr_data),
    .q_full      (q_full),
    .rel         (rel),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata)
  );

  slcd_cmd_fifo u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr_en),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_rd_en),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  slcd_ram #(
    .WIDTH (8),
    .DEPTH (slcd_pkg::RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  slcd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rd_data (q_rd_data),
    .q_rd_en   (q_rd_en),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .rel       (rel),
    .out_if    (out_if)
  );

endmodule

[hw/rtl/slcd_checker.sv]
module slcd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_data_byte,
  input logic [5:0] out_byte_index,
  input logic       out_frame_status,
  input logic       out_last
);

  // output register is empty right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=> out_valid && $stable(out_data_byte)
      && $stable(out_byte_index) && $stable(out_frame_status) && $stable(out_last))
    else $error("stalled out beat changed");

  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_frame_status |-> out_data_byte == 8'd0
      && out_byte_index == 6'd0 && out_last)
    else $error("malformed checksum error beat");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_frame_status |->
      out_last == (out_byte_index == 6'(slcd_pkg::PAYLOAD_BYTES - 1)))
    else $error("last flag not on final payload byte");

endmodule

bind sync_length_checksum_deframer slcd_checker u_slcd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_data_byte    (out_if.data_byte),
  .out_byte_index   (out_if.byte_index),
  .out_frame_status (out_if.frame_status),
  .out_last         (out_if.last)
);

[verif/sync_length_checksum_deframer_tb.sv]
module sync_length_checksum_deframer_tb;
  import slcd_pkg::*;

  localparam int SETTLE_CYCLES = 4 * PAYLOAD_BYTES + 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 5000;
  localparam int PHASE_ITEMS   = 82;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [5:0] byte_index;
    logic       frame_status;
    logic       last;
  } beat_t;

  // Tracks the frame parser and holds the beats still owed by the block.
  class frame_scoreboard;
    logic [7:0] first_sync;
    logic [7:0] second_sync;
    phase_t     ph;
    logic [7:0] run_sum;
    int         taken;
    logic [7:0] payload [PAYLOAD_BYTES];
    beat_t      pending_beats [$];
    int         mismatches;

    function new();
      first_sync  = FIRST_SYNC_RST;
      second_sync = SECOND_SYNC_RST;
      ph          = PH_SYNC1;
      run_sum     = '0;
      taken       = 0;
      mismatches  = 0;
      foreach (payload[i]) payload[i] = '0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [7:0] val);
      case (idx)
        CFG_FIRST_SYNC:  first_sync = val;
        CFG_SECOND_SYNC: second_sync = val;
        default: ;
      endcase
    endfunction

    function void take_byte(logic [7:0] b);
      beat_t bt;
      case (ph)
        PH_SYNC1: if (b == first_sync) ph = PH_SYNC2;
        // a failed second sync or length byte is dropped, not rechecked
        PH_SYNC2: ph = (b == second_sync) ? PH_LEN : PH_SYNC1;
        PH_LEN: begin
          if (b == LEN_BYTE) begin
            run_sum = '0;
            taken   = 0;
            ph      = PH_DATA;
          end else begin
            ph = PH_SYNC1;
          end
        end
        PH_DATA: begin
          payload[taken] = b;
          run_sum        = run_sum + b;
          taken++;
          if (taken == PAYLOAD_BYTES) ph = PH_SUM;
        end
        PH_SUM: begin
          if (b == run_sum) begin
            for (int k = 0; k < PAYLOAD_BYTES; k++) begin
              bt.data_byte    = payload[k];
              bt.byte_index   = 6'(k);
              bt.frame_status = ST_OK;
              bt.last         = (k == PAYLOAD_BYTES - 1);
              pending_beats.push_back(bt);
            end
          end else begin
            bt = '{8'd0, 6'd0, ST_ERR, 1'b1};
            pending_beats.push_back(bt);
          end
          ph = PH_SYNC1;
        end
        default: ph = PH_SYNC1;
      endcase
    endfunction

    function void flag(string what, beat_t want, beat_t got);
      mismatches++;
      if (mismatches <= 10)
        $display({"ERROR: %s: exp data=%02h idx=%0d st=%0b last=%0b, ",
                  "got data=%02h idx=%0d st=%0b last=%0b"},
                 what, want.data_byte, want.byte_index, want.frame_status, want.last,
                 got.data_byte, got.byte_index, got.frame_status, got.last);
    endfunction

    function void check_beat(beat_t got);
      beat_t want;
      if (pending_beats.size() == 0) begin
        flag("unexpected beat", '0, got);
      end else begin
        want = pending_beats.pop_front();
        if (want.data_byte != got.data_byte || want.byte_index != got.byte_index ||
            want.frame_status != got.frame_status || want.last != got.last)
          flag("beat mismatch", want, got);
      end
    endfunction

    function void finish_check();
      if (pending_beats.size() != 0) begin
        $display("ERROR: %0d expected beats never arrived", pending_beats.size());
        mismatches += pending_beats.size();
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  slcd_in_if  in_if ();
  slcd_out_if out_if ();
  slcd_cfg_if cfg_if ();

  sync_length_checksum_deframer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  frame_scoreboard sb = new();

  bit         no_idle   = 1'b0;
  int         hold_reqs = 0;
  int         hold_done = 0;
  int         hold_left = 0;
  int         quiet_cycles = 0;
  int         items;
  logic [7:0] cur_first  = FIRST_SYNC_RST;
  logic [7:0] cur_second = SECOND_SYNC_RST;
  logic [7:0] frame_payload [PAYLOAD_BYTES];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random backpressure plus one long hold-off
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_reqs != hold_done) begin
        hold_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= no_idle || ($urandom_range(99) >= 18);
      end
    end
  end

  // monitors and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready)
        sb.check_beat('{out_if.data_byte, out_if.byte_index, out_if.frame_status,
                        out_if.last});
      if (in_if.valid && in_if.ready)
        sb.take_byte(in_if.rx_byte);
      if (cfg_if.valid && cfg_if.ready)
        sb.write_reg(cfg_reg_t'(cfg_if.index), cfg_if.data);
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("TIMEOUT: no beat moved for %0d cycles", STALL_LIMIT);
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 18) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // header, length, payload, then the checksum offset by skew (0 = good frame)
  task automatic send_frame(input logic [7:0] skew);
    logic [7:0] total;
    total = '0;
    send_byte(cur_first);
    send_byte(cur_second);
    send_byte(LEN_BYTE);
    foreach (frame_payload[i]) begin
      send_byte(frame_payload[i]);
      total = total + frame_payload[i];
    end
    send_byte(total + skew);
  endtask

  task automatic fill_payload();
    int mode;
    mode = $urandom_range(9);
    foreach (frame_payload[i])
      frame_payload[i] = (mode == 0) ? 8'h00 : (mode == 1) ? 8'hFF : 8'($urandom);
  endtask

  // sender pause: wait for every owed beat, then let the back end go quiet
  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_syncs(input logic [7:0] first, input logic [7:0] second);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CFG_FIRST_SYNC;
    cfg_if.data  <= first;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.index <= CFG_SECOND_SYNC;
    cfg_if.data  <= second;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    cur_first  = first;
    cur_second = second;
  endtask

  task automatic random_traffic();
    int r;
    logic [7:0] b;
    items = 0;
    while (items < PHASE_ITEMS) begin
      r = $urandom_range(99);
      if (r < 62) begin
        fill_payload();
        send_frame(8'd0);
        items += PAYLOAD_BYTES + 4;
      end else if (r < 77) begin
        fill_payload();
        send_frame(8'($urandom_range(255, 1)));
        items += PAYLOAD_BYTES + 4;
      end else if (r < 85) begin
        // broken header; often the second byte repeats the first sync
        send_byte(cur_first);
        send_byte($urandom_range(1) ? cur_first : 8'($urandom));
        items += 2;
      end else if (r < 93) begin
        case ($urandom_range(4))
          0: b = LEN_BYTE - 8'd1;
          1: b = LEN_BYTE + 8'd1;
          2: b = $urandom_range(1) ? 8'h00 : 8'hFF;
          3: b = cur_first;
          default: b = 8'($urandom);
        endcase
        if (b == LEN_BYTE) b = LEN_BYTE + 8'd1;
        send_byte(cur_first);
        send_byte(cur_second);
        send_byte(b);
        items += 3;
      end else begin
        repeat ($urandom_range(5, 1)) begin
          send_byte(8'($urandom));
          items++;
        end
      end
    end
  endtask

  initial begin
    in_if.valid   = 1'b0;
    in_if.rx_byte = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = CFG_FIRST_SYNC;
    cfg_if.data   = '0;
    rst_n         = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // repeated first sync in second slot, stray byte, length equal to first sync
    send_byte(cur_first);
    send_byte(cur_first);
    send_byte(cur_second);
    send_byte(cur_first);
    send_byte(cur_second);
    send_byte(cur_first);
    frame_payload = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE,
                      8'h55, 8'hAA, 8'h0F, 8'hF0, 8'hC3, 8'h3C};
    send_frame(8'd0);
    random_traffic();

    for (int p = 1; p < 5; p++) begin
      settle();
      case (p)
        1: program_syncs(8'h00, 8'hFF);
        2: program_syncs(8'hFF, 8'h00);
        3: program_syncs(LEN_BYTE, LEN_BYTE);
        default: program_syncs(8'($urandom), 8'($urandom));
      endcase
      no_idle = (p == 2);
      if (p == 3) hold_reqs++;
      random_traffic();
    end
    no_idle = 1'b0;

    settle();
    sb.finish_check();
    if (sb.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
